FILE: rtl/core/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared codes and types for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

  // fit policy codes (code three falls back to first fit)
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // item kinds
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 1'b1;
  localparam int unsigned CFG_DATA_W = 5;

  // fixed field widths
  localparam int unsigned IDX_FIELD_W = 4;
  localparam int unsigned AMT_W       = 16;
  localparam int unsigned REQ_NUM_W   = 16;
  localparam int unsigned TDATA_W     = 24;
  localparam logic [REQ_NUM_W-1:0] BATCH_MAX = '1;

  localparam logic [4:0] BLOCKS_RESET = 5'd16;

  // decision of the compare unit for one scanned entry
  typedef struct packed {
    logic take;  // entry becomes the current pick
    logic stop;  // first fit hit, scan can end
  } fit_t;

endpackage

FILE: rtl/core/fpba_fit_unit.sv
// ----------------------------------------------------------------------------
// fpba_fit_unit
// Shared compare unit: checks one table entry against the request and the
// current pick under the active policy.
// ----------------------------------------------------------------------------
module fpba_fit_unit import fpba_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic [1:0]   policy_i,
  input  logic         found_i,
  input  logic [W-1:0] free_i,
  input  logic [W-1:0] best_i,
  input  logic [W-1:0] amount_i,
  output fit_t         fit_o
);

  logic fits;
  logic better;
  logic pol_scan;

  assign fits     = (free_i >= amount_i);
  assign pol_scan = (policy_i == POL_BEST) || (policy_i == POL_WORST);

  always_comb begin
    case (policy_i)
      POL_BEST:  better = (free_i < best_i);
      POL_WORST: better = (free_i > best_i);
      default:   better = 1'b0;
    endcase
  end

  assign fit_o.take = fits && (!found_i || better);
  assign fit_o.stop = fits && !found_i && !pol_scan;

endmodule

FILE: rtl/core/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-space table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// Each transfer on the slave stream is either a load (tuser = 0), which sets
// one block's free size, or an allocation request (tuser = 1), which scans
// blocks 0 .. min(blocks_in_use, NUM_BLOCKS)-1 one entry per cycle through a
// single compare unit fed by the table's registered read port. First fit ends
// the scan at the first block that is large enough; best and worst fit scan
// all blocks, ties going to the lower index. The chosen block's free size is
// then reduced by the request. Every item yields one result transfer.
// A load goes straight to its result; a request scans, writes the chosen
// entry back and then forms its result, a first-fit hit ending the scan
// early. s_axis_tready is low while an item is in work; a finished result
// sits in the output register so the next item can be taken while it
// waits. The table reads as zero after reset through per-entry valid
// bits, so no clearing pass is needed. Configuration is written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i (0: fit_policy, 1: blocks_in_use);
// the user must write it only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator import fpba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 16,
  parameter int unsigned SIZE_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_W-1:0]    s_axis_tdata,   // [3:0] block_index, [19:4] amount
  input  logic                  s_axis_tuser,   // [0] cmd
  input  logic                  s_axis_tlast,   // last_request
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // [3:0] chosen_block, [19:4] request_number
  output logic                  m_axis_tuser    // [0] granted
);

  localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_RESULT
  } state_e;

  state_e state_q;

  // configuration
  logic [1:0] pol_q;
  logic [4:0] bu_q;

  // input fields
  logic [IDX_FIELD_W-1:0] in_idx;
  logic [AMT_W-1:0]       in_amt;
  logic                   in_acc;
  logic [IDX_W+IDX_FIELD_W-1:0] in_idx_ext;
  logic                   idx_ok;

  assign in_idx     = s_axis_tdata[IDX_FIELD_W-1:0];
  assign in_amt     = s_axis_tdata[IDX_FIELD_W +: AMT_W];
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign in_idx_ext = {{IDX_W{1'b0}}, in_idx};
  assign idx_ok     = (32'(in_idx) < NUM_BLOCKS);

  // table storage: memory plus reset-cleared valid bits
  logic [SIZE_BITS-1:0]  mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_q;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SIZE_BITS-1:0]  wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic [SIZE_BITS-1:0]  rd_data_q;
  logic                  rd_vld_q;

  // scan state
  logic [CNT_W-1:0]     j_q;
  logic [CNT_W-1:0]     scan_lim;
  logic                 pend_q;
  logic [IDX_W-1:0]     pend_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     pick_q;
  logic [SIZE_BITS-1:0] best_q;
  logic [AMT_W-1:0]     amt_q;
  logic                 issue;
  logic                 scan_done;

  // batch bookkeeping
  logic [REQ_NUM_W-1:0] bc_q;
  logic [REQ_NUM_W-1:0] bc_inc;
  logic [REQ_NUM_W-1:0] rn_q;

  // result holding
  logic                   res_gnt_q;
  logic [IDX_FIELD_W-1:0] res_blk_q;
  logic [REQ_NUM_W-1:0]   res_num_q;
  logic [IDX_W+IDX_FIELD_W-1:0] pick_ext;

  // output register
  logic                   m_valid_q;
  logic                   m_gnt_q;
  logic [IDX_FIELD_W-1:0] m_blk_q;
  logic [REQ_NUM_W-1:0]   m_num_q;
  logic                   out_free;

  // compare unit signals
  logic [CMP_W-1:0]     cmp_free;
  logic [CMP_W-1:0]     cmp_best;
  logic [CMP_W-1:0]     cmp_amt;
  logic [SIZE_BITS-1:0] cur_free;
  fit_t                 fit;

  assign scan_lim = (32'(bu_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bu_q);
  assign issue    = (state_q == S_SCAN) && (j_q < scan_lim);
  assign rd_addr  = j_q[IDX_W-1:0];
  assign cur_free = rd_vld_q ? rd_data_q : '0;

  assign cmp_free = CMP_W'(cur_free);
  assign cmp_best = CMP_W'(best_q);
  assign cmp_amt  = CMP_W'(amt_q);

  fpba_fit_unit #(
    .W (CMP_W)
  ) u_fit (
    .policy_i (pol_q),
    .found_i  (found_q),
    .free_i   (cmp_free),
    .best_i   (cmp_best),
    .amount_i (cmp_amt),
    .fit_o    (fit)
  );

  // scan ends on a first-fit hit or once every entry has been compared
  assign scan_done = (pend_q && fit.stop) || !issue;

  assign bc_inc   = (bc_q == BATCH_MAX) ? bc_q : bc_q + 1'b1;
  assign pick_ext = {{IDX_FIELD_W{1'b0}}, pick_q};
  assign out_free = !m_valid_q || m_axis_tready;

  // single write port: loads at accept, allocation update afterwards
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_q;
    wr_data = best_q - SIZE_BITS'(amt_q);
    if (state_q == S_IDLE) begin
      wr_en   = in_acc && (s_axis_tuser == CMD_LOAD) && idx_ok;
      wr_addr = in_idx_ext[IDX_W-1:0];
      wr_data = SIZE_BITS'(in_amt);
    end else if (state_q == S_UPDATE) begin
      wr_en = found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
    rd_vld_q  <= vld_q[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pol_q      <= POL_FIRST;
      bu_q       <= BLOCKS_RESET;
      vld_q      <= '0;
      bc_q       <= '0;
      rn_q       <= '0;
      j_q        <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      found_q    <= 1'b0;
      pick_q     <= '0;
      best_q     <= '0;
      amt_q      <= '0;
      res_gnt_q  <= 1'b0;
      res_blk_q  <= '0;
      res_num_q  <= '0;
      m_valid_q  <= 1'b0;
      m_gnt_q    <= 1'b0;
      m_blk_q    <= '0;
      m_num_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FIT_POLICY:    pol_q <= cfg_wdata_i[1:0];
          CFG_BLOCKS_IN_USE: bu_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end

      // drained result; a new one loaded in S_RESULT takes its place
      if (m_axis_tready && (state_q != S_RESULT)) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == CMD_LOAD) begin
              res_gnt_q <= 1'b0;
              res_blk_q <= in_idx;
              res_num_q <= '0;
              state_q   <= S_RESULT;
            end else begin
              amt_q   <= in_amt;
              j_q     <= '0;
              pend_q  <= 1'b0;
              found_q <= 1'b0;
              pick_q  <= '0;
              best_q  <= '0;
              rn_q    <= bc_inc;
              bc_q    <= s_axis_tlast ? '0 : bc_inc;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pend_q && fit.take) begin
            found_q <= 1'b1;
            pick_q  <= pend_idx_q;
            best_q  <= cur_free;
          end
          pend_q     <= issue;
          pend_idx_q <= rd_addr;
          if (issue) begin
            j_q <= j_q + 1'b1;
          end
          if (scan_done) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          res_gnt_q <= found_q;
          res_blk_q <= found_q ? pick_ext[IDX_FIELD_W-1:0] : '0;
          res_num_q <= rn_q;
          state_q   <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_gnt_q   <= res_gnt_q;
            m_blk_q   <= res_blk_q;
            m_num_q   <= res_num_q;
            state_q   <= S_IDLE;
          end else begin
            m_valid_q <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_gnt_q;
  assign m_axis_tdata  = {{(TDATA_W - IDX_FIELD_W - REQ_NUM_W){1'b0}}, m_num_q, m_blk_q};

endmodule

FILE: rtl/core/fpba_checker.sv
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks for the fit-policy block allocator.
// ----------------------------------------------------------------------------
module fpba_checker import fpba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // one item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  // a grant always belongs to a counted request
  a_grant_num: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[19:4] != '0))
    else $error("grant with zero request number");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/fit_policy_block_allocator_tb.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// Self-checking stream testbench for the fit-policy block allocator.
// ----------------------------------------------------------------------------
// The driver feeds load and allocation transfers from a queue. The testbench
// keeps its own copy of the free-space table and the batch counter. Each
// accepted transfer updates that copy and queues the expected result. The
// monitor compares every result transfer, field by field, with the oldest
// entry in that queue. The run starts with a directed pass over the extremes
// and the corner cases. Random phases follow under first, best and worst fit,
// policy code three, and scan widths from zero to above the table size.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
  import fpba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BLOCKS = 16;
  localparam int unsigned SIZE_BITS  = 16;

  localparam logic [1:0] POL_CODE3 = 2'd3;   // unused code, acts as first fit

  localparam int unsigned DRAIN_TAIL = 30;    // > worst item latency
  localparam int unsigned LONG_HOLD  = 400;   // receiver back-pressure stretch
  localparam int unsigned IDLE_LIMIT = 3000;  // watchdog: cycles w/o a transfer

  typedef struct packed {
    logic                 cmd;
    logic [3:0]           blk;
    logic [AMT_W-1:0]     amount;
    logic                 last;
  } alloc_item_t;

  typedef struct packed {
    logic                 granted;
    logic [3:0]           block;
    logic [REQ_NUM_W-1:0] req_num;
  } alloc_result_t;

  typedef enum logic [1:0] {RCV_STEADY, RCV_CHOPPY, RCV_SPARSE} rcv_mode_e;

  // clock, reset, DUT ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_FIT_POLICY;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;   // [3:0] block_index, [19:4] amount
  logic                  s_axis_tuser  = 1'b0; // [0] cmd
  logic                  s_axis_tlast  = 1'b0; // last_request
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;         // [3:0] chosen_block, [19:4] request_number
  logic                  m_axis_tuser;         // [0] granted

  // shadow state of the allocator
  logic [SIZE_BITS-1:0]  free_tbl [NUM_BLOCKS];
  logic [REQ_NUM_W-1:0]  batch_cnt;
  logic [1:0]            policy_cfg;
  logic [4:0]            scan_cfg;

  alloc_item_t           item_q[$];     // transfers waiting for the driver
  alloc_result_t         result_q[$];   // expected results, oldest first

  int unsigned in_offers   = 0;  // transfers put on the slave side
  int unsigned in_accepts  = 0;  // slave transfers taken by the DUT
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_loads     = 0;
  int unsigned n_reqs      = 0;
  int unsigned n_grants    = 0;
  int unsigned n_settings  = 0;
  logic [REQ_NUM_W-1:0] top_req_num = '0;

  // sender shaping
  int unsigned gap_max    = 0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  // receiver shaping; hold_req is bumped to ask for one long hold-off
  int unsigned hold_req  = 0;
  int unsigned hold_ack  = 0;
  int unsigned hold_left = 0;
  int unsigned mode_left = 0;
  rcv_mode_e   rcv_mode  = RCV_STEADY;

  fit_policy_block_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // --------------------------------------------------------------------------
  // Shadow allocator: applies one accepted transfer, returns the result.
  // A load just writes the table. A request scans the first blocks; the scan
  // width saturates at the table size. Strict compares keep ties on the
  // lower index. Refused requests leave the table alone and report block 0.
  // --------------------------------------------------------------------------
  function automatic alloc_result_t alloc_predict(alloc_item_t it);
    alloc_result_t res;
    int unsigned   span;
    int unsigned   j;
    logic          found;
    logic [3:0]    pick;
    res   = '0;
    found = 1'b0;
    pick  = '0;
    if (it.cmd == CMD_LOAD) begin
      free_tbl[it.blk] = it.amount;
      res.block = it.blk;
      return res;
    end
    span = (scan_cfg > NUM_BLOCKS) ? NUM_BLOCKS : scan_cfg;
    for (j = 0; j < span; j++) begin
      if (free_tbl[j] >= it.amount) begin
        if (!found) begin
          found = 1'b1;
          pick  = j[3:0];
          if (policy_cfg != POL_BEST && policy_cfg != POL_WORST) break;
        end else if (policy_cfg == POL_BEST && free_tbl[j] < free_tbl[pick]) begin
          pick = j[3:0];
        end else if (policy_cfg == POL_WORST && free_tbl[j] > free_tbl[pick]) begin
          pick = j[3:0];
        end
      end
    end
    if (found) free_tbl[pick] = free_tbl[pick] - it.amount;
    if (batch_cnt != BATCH_MAX) batch_cnt = batch_cnt + 1'b1;
    res.granted = found;
    res.block   = found ? pick : 4'd0;
    res.req_num = batch_cnt;
    if (it.last) batch_cnt = '0;
    return res;
  endfunction

  function automatic alloc_item_t mk_item(logic cmd, logic [3:0] blk,
                                          logic [AMT_W-1:0] amount, logic last);
    alloc_item_t it;
    it.cmd    = cmd;
    it.blk    = blk;
    it.amount = amount;
    it.last   = last;
    return it;
  endfunction

  task automatic report(string field, int unsigned got, int unsigned want);
    if (mismatches < 50)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  // register write, DUT and shadow copy together (block is idle here)
  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_FIT_POLICY) policy_cfg = val[1:0];
    else                       scan_cfg   = val;
    n_settings++;
  endtask

  // sender pause: everything accepted and every result back, then a tail
  task automatic wait_drained();
    while (item_q.size() != 0 || in_accepts != in_offers || result_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  // random mix of loads and requests; sizes lean small so grants and
  // refusals both happen often, with full-range values and extremes mixed in
  task automatic queue_random(int unsigned count);
    alloc_item_t it;
    int unsigned k;
    for (k = 0; k < count; k++) begin
      it.blk  = 4'($urandom);
      it.last = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 3) begin
        it.cmd = CMD_LOAD;
        case ($urandom_range(0, 9)) inside
          [0:4]:   it.amount = 16'($urandom);
          [5:7]:   it.amount = 16'($urandom_range(0, 1000));
          8:       it.amount = '1;
          default: it.amount = '0;
        endcase
      end else begin
        it.cmd = CMD_ALLOC;
        case ($urandom_range(0, 9)) inside
          [0:3]:   it.amount = 16'($urandom_range(0, 300));
          [4:6]:   it.amount = 16'($urandom_range(0, 4000));
          [7:8]:   it.amount = 16'($urandom);
          default: it.amount = ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
      end
      item_q.push_back(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: slave side, changes at the falling edge. A transfer stays up
  // until the monitor has counted it as accepted. Bursts of random length
  // alternate with random gaps; gap_max 0 gives back-to-back offers.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    alloc_item_t nxt;
    logic        offer;
    if (rst_ni && (!s_axis_tvalid || in_accepts == in_offers)) begin
      offer = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (item_q.size() != 0) begin
        nxt   = item_q.pop_front();
        offer = 1'b1;
        in_offers++;
        s_axis_tdata <= {4'b0, nxt.amount, nxt.blk};
        s_axis_tuser <= nxt.cmd;
        s_axis_tlast <= nxt.last;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: master-side ready. It picks its own stall mode, steady,
  // choppy or sparse, at random intervals. A long hold-off, when asked for,
  // keeps ready low so the output register fills and the DUT stalls its input.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rcv_mode  = rcv_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rcv_mode)
          RCV_STEADY: m_axis_tready <= 1'b1;
          RCV_CHOPPY: m_axis_tready <= ($urandom_range(0, 1) != 0);
          default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both sides at the rising edge. An accepted slave
  // transfer runs through the shadow allocator; a master transfer is
  // checked against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_item_t   it;
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it   = mk_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4], s_axis_tlast);
        want = alloc_predict(it);
        result_q.push_back(want);
        in_accepts++;
        if (it.cmd == CMD_LOAD) begin
          n_loads++;
        end else begin
          n_reqs++;
          if (want.granted) n_grants++;
          if (want.req_num > top_req_num) top_req_num = want.req_num;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.granted = m_axis_tuser;
        got.block   = m_axis_tdata[3:0];
        got.req_num = m_axis_tdata[19:4];
        if (result_q.size() == 0) begin
          report("unexpected result transfer", got, 0);
        end else begin
          want = result_q.pop_front();
          if (got.granted != want.granted) report("granted", got.granted, want.granted);
          if (got.block != want.block)     report("chosen_block", got.block, want.block);
          if (got.req_num != want.req_num) report("request_number", got.req_num, want.req_num);
        end
      end
    end
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("fit_policy_block_allocator_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed pass, random phases.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    int unsigned ph;
    logic [1:0]  ph_pol [6];
    logic [4:0]  ph_scan [6];
    int unsigned ph_len [6];

    for (k = 0; k < NUM_BLOCKS; k++) free_tbl[k] = '0;
    batch_cnt  = '0;
    policy_cfg = POL_FIRST;
    scan_cfg   = BLOCKS_RESET;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table after reset: a zero-size request fits block 0, one unit not
    gap_max = 3;
    item_q.push_back(mk_item(CMD_ALLOC, 4'd9,  16'd0,      1'b0));
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd1,      1'b0));
    item_q.push_back(mk_item(CMD_LOAD,  4'd0,  16'hFFFF,   1'b0));
    item_q.push_back(mk_item(CMD_LOAD,  4'd15, 16'd50,     1'b1));
    item_q.push_back(mk_item(CMD_LOAD,  4'd7,  16'd50,     1'b0));
    item_q.push_back(mk_item(CMD_LOAD,  4'd3,  16'd300,    1'b0));
    // first fit takes block 0; a request above every block is refused
    item_q.push_back(mk_item(CMD_ALLOC, 4'd15, 16'd40,     1'b0));
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'hFFFF,   1'b1));
    wait_drained();

    // best fit: two equal blocks, lower index first
    set_reg(CFG_FIT_POLICY, {3'b000, POL_BEST});
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd50,     1'b0));
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd50,     1'b0));
    wait_drained();

    // worst fit; a full-size request empties a full block
    set_reg(CFG_FIT_POLICY, {3'b000, POL_WORST});
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd10,     1'b0));
    item_q.push_back(mk_item(CMD_LOAD,  4'd1,  16'hFFFF,   1'b0));
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'hFFFF,   1'b1));
    wait_drained();

    // policy code three, upper data bits set as well
    set_reg(CFG_FIT_POLICY, {3'b111, POL_CODE3});
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd20,     1'b0));
    wait_drained();

    // nothing scanned: even a zero-size request is refused
    set_reg(CFG_BLOCKS_IN_USE, 5'd0);
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd0,      1'b0));
    wait_drained();

    // scan width above the table size saturates; only the top block fits
    set_reg(CFG_FIT_POLICY, {3'b000, POL_WORST});
    set_reg(CFG_BLOCKS_IN_USE, 5'd31);
    item_q.push_back(mk_item(CMD_LOAD,  4'd15, 16'hFFFF,   1'b0));
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'hFFF0,   1'b0));
    wait_drained();

    // single block scanned
    set_reg(CFG_BLOCKS_IN_USE, 5'd1);
    item_q.push_back(mk_item(CMD_ALLOC, 4'd0,  16'd300,    1'b1));
    item_q.push_back(mk_item(CMD_ALLOC, 4'd5,  16'd0,      1'b1));
    wait_drained();

    // random phases, one setting of both registers each
    ph_pol  = '{POL_FIRST, POL_BEST, POL_WORST, POL_CODE3, 2'($urandom), POL_BEST};
    ph_scan = '{5'd16, 5'd3, 5'd31, 5'd16, 5'($urandom_range(2, 15)), 5'd0};
    ph_len  = '{300, 300, 300, 300, 250, 60};
    for (ph = 0; ph < 6; ph++) begin
      set_reg(CFG_FIT_POLICY, {3'($urandom), ph_pol[ph]});
      set_reg(CFG_BLOCKS_IN_USE, ph_scan[ph]);
      // phase 2: sender streams back to back while the receiver holds off
      if (ph == 2) begin
        gap_max = 0;
        hold_req++;
      end else begin
        gap_max = (ph % 2 == 0) ? 0 : $urandom_range(4, 20);
      end
      queue_random(ph_len[ph]);
      wait_drained();
    end

    if (result_q.size() != 0) report("results never delivered", result_q.size(), 0);

    $display("covered %0d loads and %0d requests (%0d granted, %0d refused)",
             n_loads, n_reqs, n_grants, n_reqs - n_grants);
    $display("over %0d register writes; highest request number 0x%0h",
             n_settings, top_req_num);
    if (mismatches == 0) begin
      $display("fit_policy_block_allocator_tb: done, clean");
    end else begin
      $display("fit_policy_block_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/fpba_pkg.sv
rtl/core/fpba_fit_unit.sv
rtl/core/fit_policy_block_allocator.sv
rtl/core/fpba_checker.sv
tb/sv/fit_policy_block_allocator_tb.sv
